@@ rtl/cbpb_pkg.sv @@
// ----------------------------------------------------------------------------
// cbpb_pkg
// Shared constants and types for the camera byte pixel binarizer.
// ----------------------------------------------------------------------------
package cbpb_pkg;

  localparam int DATA_W      = 8;
  localparam int POS_W       = 7;
  localparam int COLOR_W     = 16;
  localparam int OUT_PACK_W  = 2 * POS_W + COLOR_W;
  localparam int OUT_TDATA_W = ((OUT_PACK_W + 7) / 8) * 8;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 8;
  localparam int THR_W       = 8;
  localparam int LUMA_SUM_W  = 16;

  localparam int DEF_FRAME_WIDTH  = 320;
  localparam int DEF_FRAME_HEIGHT = 240;
  localparam int DEF_CROP_SIZE    = 128;

  localparam logic             MODE_RESET      = 1'b1;
  localparam logic [THR_W-1:0] THRESHOLD_RESET = 8'd90;

  localparam logic [COLOR_W-1:0] MASK_R = 16'hf800;
  localparam logic [COLOR_W-1:0] MASK_G = 16'h07e0;
  localparam logic [COLOR_W-1:0] MASK_B = 16'h001f;

  localparam logic [LUMA_SUM_W-1:0] COEF_R    = 16'd31;
  localparam logic [LUMA_SUM_W-1:0] COEF_G    = 16'd59;
  localparam logic [LUMA_SUM_W-1:0] COEF_B    = 16'd11;
  localparam logic [LUMA_SUM_W-1:0] LUMA_DIV  = 16'd100;

  localparam logic [COLOR_W-1:0] COLOR_WHITE = 16'hffff;
  localparam logic [COLOR_W-1:0] COLOR_BLACK = 16'h0000;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODE      = 2'd0,
    REG_THRESHOLD = 2'd1
  } cfg_reg_t;

endpackage

@@ rtl/cbpb_luma.sv @@
// ----------------------------------------------------------------------------
// cbpb_luma
// Converts an RGB565 pixel to black or white by luma threshold, or passes it.
// ----------------------------------------------------------------------------
module cbpb_luma (
  input  logic [cbpb_pkg::COLOR_W-1:0] pixel,
  input  logic                         mode,
  input  logic [cbpb_pkg::THR_W-1:0]   threshold,
  output logic [cbpb_pkg::COLOR_W-1:0] color
);
  import cbpb_pkg::*;

  logic [LUMA_SUM_W-1:0] r8;
  logic [LUMA_SUM_W-1:0] g8;
  logic [LUMA_SUM_W-1:0] b8;
  logic [LUMA_SUM_W-1:0] luma_sum;
  logic [LUMA_SUM_W-1:0] limit;
  logic [COLOR_W-1:0]    masked_r;
  logic [COLOR_W-1:0]    masked_g;
  logic [COLOR_W-1:0]    masked_b;

  // luma / 100 > thr  <=>  sum >= 100 * (thr + 1)
  always_comb begin
    masked_r = pixel & MASK_R;
    masked_g = pixel & MASK_G;
    masked_b = pixel & MASK_B;
    r8       = LUMA_SUM_W'(masked_r >> 8);
    g8       = LUMA_SUM_W'(masked_g >> 3);
    b8       = LUMA_SUM_W'(masked_b << 3);
    luma_sum = COEF_R * r8 + COEF_G * g8 + COEF_B * b8;
    limit    = LUMA_DIV * (LUMA_SUM_W'(threshold) + 16'd1);
    if (mode) begin
      color = (luma_sum >= limit) ? COLOR_WHITE : COLOR_BLACK;
    end else begin
      color = pixel;
    end
  end

endmodule

@@ rtl/camera_byte_pixel_binarizer_unit.sv @@
// ----------------------------------------------------------------------------
// camera_byte_pixel_binarizer_unit
// Assembles RGB565 pixels from a camera byte stream and crops/binarizes them.
// ----------------------------------------------------------------------------
// The in_ channel takes one camera byte per word, high byte of a pixel first;
// in_tuser high on a word clears the frame position and byte phase before
// that byte is taken. Every second byte completes a pixel; pixels in the
// top-left CROP_SIZE square produce one out_ word with row, column and color.
// In binarize mode (cfg register 0 = 1) the color is white when the pixel
// luma exceeds cfg register 1, else black; in raw mode the pixel passes.
// An accepted low byte loads the pixel into the input register; its result
// word is then formed in the output register. The block accepts one byte
// per cycle unless in_tready drops, which it does only when both registers
// hold words and the receiver stalls. After reset: mode binarize, threshold
// 90, position zero, expecting a high byte. The cfg port is always ready;
// write it only while the block is idle.
// ----------------------------------------------------------------------------
module camera_byte_pixel_binarizer_unit #(
  parameter int FRAME_WIDTH  = cbpb_pkg::DEF_FRAME_WIDTH,
  parameter int FRAME_HEIGHT = cbpb_pkg::DEF_FRAME_HEIGHT,
  parameter int CROP_SIZE    = cbpb_pkg::DEF_CROP_SIZE
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [cbpb_pkg::DATA_W-1:0]      in_tdata,   // [7:0] data_byte
  input  logic                             in_tuser,   // [0] restart
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [cbpb_pkg::OUT_TDATA_W-1:0] out_tdata,  // [6:0] out_row, [13:7] out_col,
                                                       // [29:14] pixel_color, [31:30] zero
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [cbpb_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cbpb_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cbpb_pkg::*;

  localparam int COL_W = (FRAME_WIDTH > 1) ? $clog2(FRAME_WIDTH) : 1;
  localparam int ROW_W = (FRAME_HEIGHT > 1) ? $clog2(FRAME_HEIGHT) : 1;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(FRAME_WIDTH - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(FRAME_HEIGHT - 1);

  logic               mode_r;
  logic [THR_W-1:0]   threshold_r;
  logic               phase_r, phase_nxt;
  logic [DATA_W-1:0]  high_r, high_nxt;
  logic [COL_W-1:0]   col_r, col_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;

  logic               s1_valid_r, s1_valid_nxt;
  logic [COLOR_W-1:0] s1_pixel_r;
  logic [POS_W-1:0]   s1_row_r;
  logic [POS_W-1:0]   s1_col_r;

  logic                  out_valid_r;
  logic [OUT_PACK_W-1:0] out_data_r;

  logic               in_fire;
  logic               out_free;
  logic               s1_move;
  logic               phase_cur;
  logic [COL_W-1:0]   col_cur;
  logic [ROW_W-1:0]   row_cur;
  logic               pix_done;
  logic               in_crop;
  logic               s1_load;
  logic [31:0]        col_ext;
  logic [31:0]        row_ext;
  logic [COLOR_W-1:0] color;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid_r || out_tready;
  assign s1_move    = s1_valid_r && out_free;
  assign in_tready  = !s1_valid_r || out_free;
  assign in_fire    = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_data_r);

  always_comb begin
    phase_cur = in_tuser ? 1'b0 : phase_r;
    col_cur   = in_tuser ? '0 : col_r;
    row_cur   = in_tuser ? '0 : row_r;
    col_ext   = 32'(col_cur);
    row_ext   = 32'(row_cur);
    in_crop   = (col_ext < 32'(CROP_SIZE)) && (row_ext < 32'(CROP_SIZE));
    pix_done  = in_fire && phase_cur;
    s1_load   = pix_done && in_crop;
  end

  always_comb begin
    phase_nxt = phase_r;
    high_nxt  = high_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (in_fire) begin
      phase_nxt = !phase_cur;
      col_nxt   = col_cur;
      row_nxt   = row_cur;
      if (!phase_cur) begin
        high_nxt = in_tdata;
      end else if (col_cur == COL_LAST) begin
        col_nxt = '0;
        row_nxt = (row_cur == ROW_LAST) ? '0 : row_cur + 1'b1;
      end else begin
        col_nxt = col_cur + 1'b1;
      end
    end
  end

  always_comb begin
    if (s1_load) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r      <= MODE_RESET;
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MODE:      mode_r      <= cfg_data[0];
        REG_THRESHOLD: threshold_r <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= 1'b0;
      high_r      <= '0;
      col_r       <= '0;
      row_r       <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r    <= phase_nxt;
      high_r     <= high_nxt;
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      s1_valid_r <= s1_valid_nxt;
      if (s1_move) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_pixel_r <= {high_r, in_tdata};
      s1_row_r   <= row_ext[POS_W-1:0];
      s1_col_r   <= col_ext[POS_W-1:0];
    end
    if (s1_move) begin
      out_data_r <= {color, s1_col_r, s1_row_r};
    end
  end

  cbpb_luma u_luma (
    .pixel     (s1_pixel_r),
    .mode      (mode_r),
    .threshold (threshold_r),
    .color     (color)
  );

  a_restart_phase : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_tuser |=> phase_r && col_r == '0 && row_r == '0)
    else $error("restart did not leave position at frame start awaiting low byte");

  a_col_range : assert property (@(posedge clk) disable iff (!rst_n)
    col_r <= COL_LAST)
    else $error("column counter beyond frame width");

  a_row_range : assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= ROW_LAST)
    else $error("row counter beyond frame height");

  a_s1_hold : assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !out_free |=> s1_valid_r && $stable(s1_pixel_r))
    else $error("pending pixel lost while output stalled");

endmodule
